// ===== sv/scancode_to_ascii_fifo_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SCANCODE_TO_ASCII_FIFO_ASSERT_SVH
`define SCANCODE_TO_ASCII_FIFO_ASSERT_SVH

// Same-cycle implication.
`define SC2A_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scancode_to_ascii_fifo: assertion failed");

// Next-cycle implication.
`define SC2A_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scancode_to_ascii_fifo: assertion failed");

`endif

// ===== sv/sc2a_pkg.sv =====
package sc2a_pkg;

  localparam int CHAR_W = 7;
  localparam int CODE_W = 8;

  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CODE_W-1:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [CODE_W-1:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [CODE_W-1:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [CODE_W-1:0] SC_RSHIFT_BREAK = 8'hB6;
  localparam int                SC_BREAK_BIT    = 7;
  localparam logic [CODE_W-1:0] SC_EQUALS       = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PLUS         = 7'h2B;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    char_t ch;
    logic  is_char;
  } dec_t;

  function automatic char_t keymap(input code_t code);
    char_t ch;
    case (code)
      8'h02: ch = 7'h31;
      8'h03: ch = 7'h32;
      8'h04: ch = 7'h33;
      8'h05: ch = 7'h34;
      8'h06: ch = 7'h35;
      8'h07: ch = 7'h36;
      8'h08: ch = 7'h37;
      8'h09: ch = 7'h38;
      8'h0A: ch = 7'h39;
      8'h0B: ch = 7'h30;
      8'h0C: ch = 7'h2D;
      8'h0D: ch = 7'h3D;
      8'h0E: ch = 7'h08;
      8'h0F: ch = 7'h09;
      8'h10: ch = 7'h51;
      8'h11: ch = 7'h57;
      8'h12: ch = 7'h45;
      8'h13: ch = 7'h52;
      8'h14: ch = 7'h54;
      8'h15: ch = 7'h59;
      8'h16: ch = 7'h55;
      8'h17: ch = 7'h49;
      8'h18: ch = 7'h4F;
      8'h19: ch = 7'h50;
      8'h1A: ch = 7'h5B;
      8'h1B: ch = 7'h5D;
      8'h1C: ch = 7'h0A;
      8'h1E: ch = 7'h41;
      8'h1F: ch = 7'h53;
      8'h20: ch = 7'h44;
      8'h21: ch = 7'h46;
      8'h22: ch = 7'h47;
      8'h23: ch = 7'h48;
      8'h24: ch = 7'h4A;
      8'h25: ch = 7'h4B;
      8'h26: ch = 7'h4C;
      8'h27: ch = 7'h3B;
      8'h28: ch = 7'h27;
      8'h29: ch = 7'h60;
      8'h2B: ch = 7'h5C;
      8'h2C: ch = 7'h5A;
      8'h2D: ch = 7'h58;
      8'h2E: ch = 7'h43;
      8'h2F: ch = 7'h56;
      8'h30: ch = 7'h42;
      8'h31: ch = 7'h4E;
      8'h32: ch = 7'h4D;
      8'h33: ch = 7'h2C;
      8'h34: ch = 7'h2E;
      8'h35: ch = 7'h2F;
      8'h37: ch = 7'h2A;
      8'h39: ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/sc2a_decoder.sv =====
module sc2a_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  sc2a_pkg::code_t   scancode,
  output sc2a_pkg::dec_t    dec
);

  logic shift_held;
  logic is_make;
  logic is_shift_make;
  logic is_shift_break;
  sc2a_pkg::char_t ch;

  assign is_shift_make  = (scancode == sc2a_pkg::SC_LSHIFT_MAKE) ||
                          (scancode == sc2a_pkg::SC_RSHIFT_MAKE);
  assign is_shift_break = (scancode == sc2a_pkg::SC_LSHIFT_BREAK) ||
                          (scancode == sc2a_pkg::SC_RSHIFT_BREAK);
  assign is_make        = !scancode[sc2a_pkg::SC_BREAK_BIT];

  always_comb begin
    if (!is_make || is_shift_make) begin
      ch = '0;
    end else if (scancode == sc2a_pkg::SC_EQUALS && shift_held) begin
      ch = sc2a_pkg::CH_PLUS;
    end else begin
      ch = sc2a_pkg::keymap(scancode);
    end
  end

  assign dec.ch      = ch;
  assign dec.is_char = (ch != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
    end else if (en) begin
      if (is_shift_make) begin
        shift_held <= 1'b1;
      end else if (is_shift_break) begin
        shift_held <= 1'b0;
      end
    end
  end

endmodule

// ===== sv/scancode_to_ascii_fifo.sv =====
// Set-1 keyboard scancode decoder feeding a character FIFO. A scancode transfer
// (operation 0) updates the shift flag or decodes a make code to upper-case
// ASCII and pushes it into the FIFO; its result is ready in the next cycle. When
// the FIFO already holds FIFO_DEPTH-1 characters the decoded character is
// returned with dropped set and not stored. A read transfer (operation 1) pops
// the oldest character; from an empty FIFO it returns zeros in the next cycle,
// otherwise the character passes through the registered read port of the
// character memory and then the output register. One item is in flight at a
// time. A waiting result holds off the input; the next transfer is taken in
// the same cycle the result is taken.
module scancode_to_ascii_fifo #(
  parameter int FIFO_DEPTH = 128
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    operation,
  input  logic [7:0]              scancode,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [6:0]              character,
  output logic                    char_valid,
  output logic                    dropped
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] LAST_POS = PTR_W'(FIFO_DEPTH - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state;
  logic state_next;

  logic [PTR_W-1:0] write_pos;
  logic [PTR_W-1:0] read_pos;
  logic [PTR_W-1:0] write_pos_next;
  logic [PTR_W-1:0] read_pos_next;

  sc2a_pkg::char_t mem [FIFO_DEPTH];
  sc2a_pkg::char_t rd_data;

  sc2a_pkg::dec_t dec;

  logic accept;
  logic scan_acc;
  logic read_acc;
  logic empty;
  logic full;
  logic wr_en;
  logic rd_en;
  logic load_now;
  logic load_mem;

  sc2a_decoder u_dec (
    .clk      (clk),
    .rst      (rst),
    .en       (scan_acc),
    .scancode (scancode),
    .dec      (dec)
  );

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign scan_acc = accept && (operation == sc2a_pkg::OP_SCAN);
  assign read_acc = accept && (operation == sc2a_pkg::OP_READ);

  assign write_pos_next = (write_pos == LAST_POS) ? '0 : write_pos + 1'b1;
  assign read_pos_next  = (read_pos == LAST_POS) ? '0 : read_pos + 1'b1;

  assign empty = (write_pos == read_pos);
  assign full  = (write_pos_next == read_pos);

  assign wr_en    = scan_acc && dec.is_char && !full;
  assign rd_en    = read_acc && !empty;
  assign load_now = scan_acc || (read_acc && empty);
  assign load_mem = (state == ST_READ);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (rd_en) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[write_pos] <= dec.ch;
    end
    if (rd_en) begin
      rd_data <= mem[read_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      write_pos <= '0;
      read_pos  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (wr_en) begin
        write_pos <= write_pos_next;
      end
      if (rd_en) begin
        read_pos <= read_pos_next;
      end
      if (load_now || load_mem) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_now) begin
      character  <= scan_acc ? dec.ch : '0;
      char_valid <= scan_acc && dec.is_char;
      dropped    <= scan_acc && dec.is_char && full;
    end else if (load_mem) begin
      character  <= rd_data;
      char_valid <= 1'b1;
      dropped    <= 1'b0;
    end
  end

endmodule

// ===== sv/sc2a_checker.sv =====
`include "scancode_to_ascii_fifo_assert.svh"

module sc2a_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       operation,
  input logic [7:0] scancode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] character,
  input logic       char_valid,
  input logic       dropped
);

  logic in_xfer;

  assign in_xfer = in_valid && in_ready && (operation || (scancode != '0));

  `SC2A_ASSERT_IMP(a_drop_has_char, clk, rst, out_valid && dropped, char_valid)
  `SC2A_ASSERT_IMP(a_no_char_zero, clk, rst, out_valid && !char_valid, character == '0)
  `SC2A_ASSERT_IMP(a_char_nonzero, clk, rst, out_valid && char_valid, character != '0)
  `SC2A_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready && !in_xfer,
                   out_valid && $stable(character) && $stable(char_valid))

endmodule

bind scancode_to_ascii_fifo sc2a_checker u_sc2a_checker (.*);
